### sv/signed_integer_to_ascii_digits_defines.svh
// Assertion macros shared by the integer-to-ASCII converter modules.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef SIGNED_INTEGER_TO_ASCII_DIGITS_DEFINES_SVH
`define SIGNED_INTEGER_TO_ASCII_DIGITS_DEFINES_SVH

// same-cycle implication
`define SITOA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sitoa_pkg.sv
// Shared constants, control/status structs and helper functions for the
// integer-to-ASCII converter. No dependencies.
package sitoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_WIDTH = 5;
  localparam int DIGIT_WIDTH = 4;
  localparam int CHAR_WIDTH  = 8;

  localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_WIDTH-1:0] MINUS_CODE = 8'h2D;

  localparam logic [CHAR_WIDTH-1:0] DIGIT_CODES [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic load;
    logic go;
  } div_ctrl_t;

  typedef struct packed {
    logic                   done;
    logic                   more;
    logic [DIGIT_WIDTH-1:0] digit;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  typedef struct packed {
    logic empty;
    logic last;
  } stk_stat_t;

  function automatic logic [RADIX_WIDTH-1:0] eff_radix(input logic [RADIX_WIDTH-1:0] r);
    logic [RADIX_WIDTH-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
    return DIGIT_CODES[d];
  endfunction

endpackage

### sv/sitoa_in_if.sv
// Input channel: valid/ready handshake carrying one signed integer.
// Width follows the converter's VALUE_WIDTH.
interface sitoa_in_if #(
  parameter int WIDTH = sitoa_pkg::VALUE_WIDTH
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

### sv/sitoa_out_if.sv
// Output channel: valid/ready handshake carrying one ASCII character and
// its end-of-run flag. Uses sitoa_pkg for the character width.
interface sitoa_out_if;
  logic                               valid;
  logic                               ready;
  logic [sitoa_pkg::CHAR_WIDTH-1:0]   character;
  logic                               last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

### sv/sitoa_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, quotient kept
// in place for the next digit. Uses sitoa_pkg structs and widths.
`include "signed_integer_to_ascii_digits_defines.svh"

module sitoa_div #(
  parameter int WIDTH = sitoa_pkg::VALUE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sitoa_pkg::div_ctrl_t                 ctrl,
  input  logic [WIDTH-1:0]                     dividend,
  input  logic [sitoa_pkg::RADIX_WIDTH-1:0]    divisor,
  output sitoa_pkg::div_stat_t                 stat
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

  logic [WIDTH-1:0]                      mag;
  logic [sitoa_pkg::DIGIT_WIDTH-1:0]     rem;
  logic [sitoa_pkg::RADIX_WIDTH-1:0]     div;
  logic [CW-1:0]                         cnt;
  logic                                  busy;
  logic                                  done;
  logic                                  nz;

  logic [sitoa_pkg::RADIX_WIDTH-1:0]     rem_sh;
  logic                                  qbit;
  logic [sitoa_pkg::RADIX_WIDTH-1:0]     rem_next;

  always_comb begin
    rem_sh   = {rem, mag[WIDTH-1]};
    qbit     = (rem_sh >= div);
    rem_next = qbit ? (rem_sh - div) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (ctrl.load) begin
        mag  <= dividend;
        div  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        nz   <= 1'b0;
        busy <= 1'b1;
        done <= 1'b0;
      end else if (ctrl.go) begin
        rem  <= '0;
        cnt  <= '0;
        nz   <= 1'b0;
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        mag  <= {mag[WIDTH-2:0], qbit};
        rem  <= rem_next[sitoa_pkg::DIGIT_WIDTH-1:0];
        nz   <= nz | qbit;
        cnt  <= cnt + 1'b1;
        done <= (cnt == LAST_BIT);
        if (cnt == LAST_BIT) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign stat.done  = done;
  assign stat.more  = nz;
  assign stat.digit = rem;

  `SITOA_ASSERT_NOW(a_rem_below_radix, done, {1'b0, rem} < div, "remainder not below radix")
  `SITOA_ASSERT_NEXT(a_done_ends_pass, done, !busy || ctrl.load || ctrl.go || $past(ctrl.go), "divider busy after done without restart")

endmodule

### sv/sitoa_stack.sv
// Digit stack built as a shift line: push shifts up, pop shifts down, the
// top entry sits at a fixed tap. Uses sitoa_pkg structs and widths.
`include "signed_integer_to_ascii_digits_defines.svh"

module sitoa_stack #(
  parameter int DEPTH = sitoa_pkg::VALUE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sitoa_pkg::stk_ctrl_t               ctrl,
  input  logic [sitoa_pkg::DIGIT_WIDTH-1:0]  push_digit,
  output logic [sitoa_pkg::DIGIT_WIDTH-1:0]  top,
  output sitoa_pkg::stk_stat_t               stat
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [sitoa_pkg::DIGIT_WIDTH-1:0] entries [DEPTH];
  logic [CW-1:0]                     cnt;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entries[0] <= push_digit;
      for (int i = 1; i < DEPTH; i++) begin
        entries[i] <= entries[i-1];
      end
    end else if (ctrl.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.push) begin
      cnt <= cnt + 1'b1;
    end else if (ctrl.pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  assign top        = entries[0];
  assign stat.empty = (cnt == '0);
  assign stat.last  = (cnt == CW'(1));

  `SITOA_ASSERT_NOW(a_no_overflow, ctrl.push, cnt < CW'(DEPTH), "push onto full digit stack")
  `SITOA_ASSERT_NOW(a_no_underflow, ctrl.pop, cnt != '0, "pop from empty digit stack")
  `SITOA_ASSERT_NOW(a_push_pop_excl, ctrl.push, !ctrl.pop, "push and pop in one cycle")

endmodule

### sv/signed_integer_to_ascii_digits.sv
// Operation: each digit takes one full division pass of the magnitude by the radix;
// the digits then pass from the stack through the output register, one character per
// cycle while the sink is ready; a sign adds one character, sent first.
// Values: one value at a time, the next value is taken once the last character
// is in the output register.
// Reset: synchronous, active high; clears control state, radix returns to 10.
`include "signed_integer_to_ascii_digits_defines.svh"

module signed_integer_to_ascii_digits #(
  parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              radix_wr_en,
  input  logic [sitoa_pkg::RADIX_WIDTH-1:0] radix_wr_data,
  sitoa_in_if.sink                          number,
  sitoa_out_if.source                       text
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t                              state;
  logic [sitoa_pkg::RADIX_WIDTH-1:0]   radix;
  logic                                negative;
  logic                                out_valid;
  logic [sitoa_pkg::CHAR_WIDTH-1:0]    out_char;
  logic                                out_last;

  logic [VALUE_WIDTH-1:0]              magnitude;
  logic                                out_free;
  logic                                out_load;
  sitoa_pkg::div_ctrl_t                div_ctrl;
  sitoa_pkg::div_stat_t                div_stat;
  sitoa_pkg::stk_ctrl_t                stk_ctrl;
  sitoa_pkg::stk_stat_t                stk_stat;
  logic [sitoa_pkg::DIGIT_WIDTH-1:0]   stk_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= sitoa_pkg::RADIX_RESET;
    end else if (radix_wr_en) begin
      radix <= radix_wr_data;
    end
  end

  always_comb begin
    magnitude = number.value[VALUE_WIDTH-1] ? (~number.value + 1'b1) : number.value;
    out_free  = !out_valid || text.ready;
    out_load  = 1'b0;
    div_ctrl  = '0;
    stk_ctrl  = '0;
    unique case (state)
      S_IDLE: begin
        div_ctrl.load = number.valid;
      end
      S_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          div_ctrl.go   = div_stat.more;
        end
      end
      S_SIGN: begin
        out_load = out_free;
      end
      S_EMIT: begin
        out_load     = out_free;
        stk_ctrl.pop = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (number.valid) begin
            negative <= number.value[VALUE_WIDTH-1];
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done && !div_stat.more) begin
            state <= negative ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_char  <= sitoa_pkg::MINUS_CODE;
            out_last  <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_char  <= sitoa_pkg::digit_char(stk_top);
            out_last  <= stk_stat.last;
            if (stk_stat.last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  sitoa_div #(
    .WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (magnitude),
    .divisor  (sitoa_pkg::eff_radix(radix)),
    .stat     (div_stat)
  );

  sitoa_stack #(
    .DEPTH (VALUE_WIDTH)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (stk_ctrl),
    .push_digit (div_stat.digit),
    .top        (stk_top),
    .stat       (stk_stat)
  );

  assign number.ready   = (state == S_IDLE);
  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;

  `SITOA_ASSERT_NOW(a_accept_empty, number.valid && number.ready, stk_stat.empty, "value taken with digits pending")
  `SITOA_ASSERT_NOW(a_char_legal, out_valid, (out_char >= 8'h30 && out_char <= 8'h39) || (out_char >= 8'h41 && out_char <= 8'h46) || out_char == sitoa_pkg::MINUS_CODE, "illegal output character")

endmodule
